// ===== design/assert_macros.svh =====
// assertion macros included by the modular exponentiation top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif
`endif

// ===== design/mexp_pkg.sv =====
// types and constants for the modular exponentiation block
package mexp_pkg;

   localparam int OPERAND_BITS_DEFAULT = 32;
   localparam int FIELD_BITS = 32;

   typedef struct packed {
      logic [FIELD_BITS-1:0] base;
      logic [FIELD_BITS-1:0] exponent;
      logic [FIELD_BITS-1:0] modulus;
   } req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] power_result;
      logic                  bad_modulus;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mexp_mul_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BASE_START,
      ST_BASE_WAIT,
      ST_CHECK,
      ST_MUL_WAIT,
      ST_SQR_START,
      ST_SQR_WAIT,
      ST_FINISH
   } mexp_state_type;

endpackage

// ===== design/mexp_mulmod.sv =====
// shared modular multiplier: interleaved shift, add and conditional subtract
module mexp_mulmod #(
   parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [OPERAND_BITS-1:0]          x,
   input  logic [OPERAND_BITS-1:0]          y,
   input  logic [OPERAND_BITS-1:0]          n,
   output mexp_pkg::mexp_mul_status_type    status,
   output logic [OPERAND_BITS-1:0]          product
);
   import mexp_pkg::*;

   localparam int CW = $clog2(OPERAND_BITS);

   logic [OPERAND_BITS-1:0] r_ff, r_in;
   logic [OPERAND_BITS-1:0] x_ff, x_in;
   logic [OPERAND_BITS-1:0] y_ff, y_in;
   logic [OPERAND_BITS-1:0] n_ff, n_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    phase_ff, phase_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [OPERAND_BITS:0]   dbl;
   logic [OPERAND_BITS:0]   sum;
   logic [OPERAND_BITS:0]   red_src;
   logic [OPERAND_BITS:0]   red_diff;
   logic [OPERAND_BITS-1:0] reduced;

   // phase 0 doubles the partial product, phase 1 adds x on a set bit of y
   always_comb begin
      dbl      = {r_ff, 1'b0};
      sum      = {1'b0, r_ff} + (y_ff[OPERAND_BITS-1] ? {1'b0, x_ff} : '0);
      red_src  = phase_ff ? sum : dbl;
      red_diff = red_src - {1'b0, n_ff};
      reduced  = (red_src >= {1'b0, n_ff}) ? red_diff[OPERAND_BITS-1:0]
                                           : red_src[OPERAND_BITS-1:0];
   end

   always_comb begin
      r_in     = r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      n_in     = n_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         r_in     = '0;
         x_in     = x;
         y_in     = y;
         n_in     = n;
         cnt_in   = CW'(OPERAND_BITS - 1);
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         r_in     = reduced;
         phase_in = ~phase_ff;
         if (phase_ff) begin
            y_in = {y_ff[OPERAND_BITS-2:0], 1'b0};
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      n_ff     <= n_in;
      cnt_ff   <= cnt_in;
      phase_ff <= phase_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = r_ff;

endmodule

// ===== design/modular_exponentiation.sv =====
// modular exponentiation top level: sequencer around one shared modular multiplier
// sequence, accept to result valid: the base is reduced by a multiply, then per exponent bit up
// to the highest set one a multiply if the bit is set and a squaring, then the finish state; a
// zero modulus goes straight to the finish state, which loads the result once the output is free
// throughput: one request at a time, ready again as the result loads; a stalled result holds it
// reset: synchronous, clears the sequencer, the multiplier and the result valid, no memory
`include "assert_macros.svh"

module modular_exponentiation #(
   parameter int OPERAND_BITS = mexp_pkg::OPERAND_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mexp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mexp_pkg::rsp_type rsp_data
);
   import mexp_pkg::*;

   mexp_state_type state_ff, state_in;

   logic [OPERAND_BITS-1:0] base_ff, base_in;
   logic [OPERAND_BITS-1:0] e_ff, e_in;
   logic [OPERAND_BITS-1:0] n_ff, n_in;
   logic [OPERAND_BITS-1:0] pw_ff, pw_in;
   logic [OPERAND_BITS-1:0] acc_ff, acc_in;
   logic                    bad_ff, bad_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic [OPERAND_BITS-1:0] req_base, req_exp, req_mod;
   logic [OPERAND_BITS-1:0] one_mod;
   logic                    req_fire;
   logic                    out_free;

   logic                    mul_start;
   logic [OPERAND_BITS-1:0] mul_x, mul_y;
   logic [OPERAND_BITS-1:0] mul_product;
   mexp_mul_status_type     mul_status;

   logic                    mul_wait;
   logic                    acc_live;
   logic                    bad_rsp;

   assign req_base = req_data.base[OPERAND_BITS-1:0];
   assign req_exp  = req_data.exponent[OPERAND_BITS-1:0];
   assign req_mod  = req_data.modulus[OPERAND_BITS-1:0];
   // 1 reduced by the modulus
   assign one_mod  = (req_mod == OPERAND_BITS'(1)) ? '0 : OPERAND_BITS'(1);

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   mexp_mulmod #(
      .OPERAND_BITS(OPERAND_BITS)
   ) u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .n       (n_ff),
      .status  (mul_status),
      .product (mul_product)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_mod == '0) ? ST_FINISH : ST_BASE_START;
            end
         end
         ST_BASE_START: begin
            state_in = ST_BASE_WAIT;
         end
         ST_BASE_WAIT: begin
            if (mul_status.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (e_ff == '0) begin
               state_in = ST_FINISH;
            end else if (e_ff[0]) begin
               state_in = ST_MUL_WAIT;
            end else begin
               state_in = ST_SQR_START;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_status.done) begin
               state_in = ST_SQR_START;
            end
         end
         ST_SQR_START: begin
            state_in = ST_SQR_WAIT;
         end
         ST_SQR_WAIT: begin
            if (mul_status.done) begin
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // multiplier control
   always_comb begin
      mul_start = 1'b0;
      mul_x     = pw_ff;
      mul_y     = pw_ff;
      case (state_ff)
         ST_BASE_START: begin
            mul_start = 1'b1;
            mul_x     = acc_ff;
            mul_y     = base_ff;
         end
         ST_CHECK: begin
            mul_start = (e_ff != '0) && e_ff[0];
            mul_x     = acc_ff;
            mul_y     = pw_ff;
         end
         ST_SQR_START: begin
            mul_start = 1'b1;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      base_in      = base_ff;
      e_in         = e_ff;
      n_in         = n_ff;
      pw_in        = pw_ff;
      acc_in       = acc_ff;
      bad_in       = bad_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         base_in = req_base;
         e_in    = req_exp;
         n_in    = req_mod;
         bad_in  = (req_mod == '0);
         acc_in  = (req_mod == '0) ? '0 : one_mod;
      end
      if (mul_status.done) begin
         case (state_ff)
            ST_BASE_WAIT: begin
               pw_in = mul_product;
            end
            ST_MUL_WAIT: begin
               acc_in = mul_product;
            end
            ST_SQR_WAIT: begin
               pw_in = mul_product;
               e_in  = {1'b0, e_ff[OPERAND_BITS-1:1]};
            end
            default: begin
               pw_in = pw_ff;
            end
         endcase
      end
      if (state_ff == ST_FINISH && out_free) begin
         rsp_data_in.power_result = FIELD_BITS'(acc_ff);
         rsp_data_in.bad_modulus  = bad_ff;
         rsp_valid_in             = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      e_ff        <= e_in;
      n_ff        <= n_in;
      pw_ff       <= pw_in;
      acc_ff      <= acc_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mul_wait = state_ff inside {ST_BASE_WAIT, ST_MUL_WAIT, ST_SQR_WAIT};
   assign acc_live = (state_ff != ST_IDLE) && !bad_ff;
   assign bad_rsp  = rsp_valid && rsp_data.bad_modulus;

   `ASSERT_CLK(a_start_when_free, mul_start |-> !mul_status.busy, "multiplier started while busy")
   `ASSERT_CLK(a_done_in_wait, mul_status.done |-> mul_wait, "multiplier done outside a wait state")
   `ASSERT_CLK(a_acc_reduced, acc_live |-> (acc_ff < n_ff), "running result not reduced")
   `ASSERT_CLK(a_bad_gives_zero, bad_rsp |-> (rsp_data.power_result == '0), "error result not zero")

endmodule

// ===== tb/tb_modular_exponentiation.sv =====
// self-checking testbench for the modular exponentiation block: random handshakes, predicted powers
module tb_modular_exponentiation;
   import mexp_pkg::*;

   localparam int OPERAND_BITS = 32;
   localparam bit [63:0] OPERAND_MASK = (64'd1 << OPERAND_BITS) - 64'd1;
   localparam int RANDOM_REQUESTS = 120;
   // worst request: base reduction plus a multiply and a squaring per exponent bit
   localparam int WORST_LATENCY = 4 * OPERAND_BITS * (OPERAND_BITS + 1) + 2 * OPERAND_BITS + 2;
   localparam int DRAIN_CYCLES = WORST_LATENCY + 100;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_requests[$];
   rsp_type expected_powers[$];
   int total_requests = 0;
   int requests_accepted = 0;
   int results_checked = 0;
   int zero_modulus_results = 0;
   int error_count = 0;
   int cycles_elapsed = 0;
   int req_gap_left = 0;
   int rsp_stall_left = 0;
   logic req_taken = 1'b0;
   bit calm_phase = 1'b0;

   modular_exponentiation #(.OPERAND_BITS(OPERAND_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // right-to-left square and multiply on 64-bit products
   function automatic rsp_type predict_power(req_type r);
      rsp_type res;
      bit [63:0] acc;
      bit [63:0] pw;
      bit [63:0] ex;
      bit [63:0] n;
      res = '0;
      pw = {32'd0, r.base} & OPERAND_MASK;
      ex = {32'd0, r.exponent} & OPERAND_MASK;
      n = {32'd0, r.modulus} & OPERAND_MASK;
      if (n == 64'd0) begin
         res.bad_modulus = 1'b1;
         return res;
      end
      acc = 64'd1 % n;
      pw = pw % n;
      while (ex != 64'd0) begin
         if (ex[0])
            acc = (acc * pw) % n;
         ex = ex >> 1;
         pw = (pw * pw) % n;
      end
      res.power_result = acc[31:0];
      return res;
   endfunction

   function automatic logic [31:0] rand_bits(int width);
      bit [63:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return $urandom & mask[31:0];
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 50)
         return 0;
      else if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_request(logic [31:0] b, logic [31:0] e, logic [31:0] n);
      req_type r;
      r.base = b;
      r.exponent = e;
      r.modulus = n;
      pending_requests.insert(pending_requests.size(), r);
      total_requests++;
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycles_elapsed, msg);
      error_count++;
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         req_valid <= 1'b1;
      end else if (req_gap_left > 0) begin
         req_valid <= 1'b0;
         req_gap_left--;
      end else if (pending_requests.size() > 0) begin
         req_valid <= 1'b1;
         req_data <= pending_requests.pop_front();
         req_gap_left = pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm_phase && $urandom_range(0, 2) == 0)
            rsp_stall_left = pick_gap();
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            expected_powers.insert(expected_powers.size(), predict_power(req_data));
            requests_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            calm_phase <= ($urandom_range(0, 5) == 0);
            if (rsp_data.bad_modulus)
               zero_modulus_results++;
            if (expected_powers.size() == 0) begin
               report_mismatch($sformatf("result %0h/%0b with no request outstanding",
                                         rsp_data.power_result, rsp_data.bad_modulus));
            end else begin
               want = expected_powers.pop_front();
               if (rsp_data.power_result !== want.power_result)
                  report_mismatch($sformatf("power_result %0h, expected %0h",
                                            rsp_data.power_result, want.power_result));
               if (rsp_data.bad_modulus !== want.bad_modulus)
                  report_mismatch($sformatf("bad_modulus %0b, expected %0b",
                                            rsp_data.bad_modulus, want.bad_modulus));
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycles_elapsed < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_elapsed++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycles_elapsed,
               expected_powers.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      int kind;
      logic [31:0] b;
      logic [31:0] e;
      logic [31:0] n;
      int w;

      // zero modulus
      add_request(32'd5, 32'd3, 32'd0);
      add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      add_request(32'd0, 32'd0, 32'd0);
      // modulus of one, 0^0 included
      add_request(32'd0, 32'd0, 32'd1);
      add_request(32'hFFFF_FFFF, 32'd7, 32'd1);
      add_request(32'd3, 32'd0, 32'd1);
      // zero exponent
      add_request(32'd0, 32'd0, 32'd7);
      add_request(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
      add_request(32'd12, 32'd0, 32'd2);
      // zero base, base equal to and above the modulus
      add_request(32'd0, 32'd5, 32'd13);
      add_request(32'd13, 32'd9, 32'd13);
      add_request(32'd1000, 32'd1, 32'd97);
      // field extremes
      add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_request(32'hFFFF_FFFE, 32'd2, 32'hFFFF_FFFF);
      add_request(32'd2, 32'hFFFF_FFFF, 32'd3);
      add_request(32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFB);
      add_request(32'h8000_0001, 32'd3, 32'h8000_0000);
      add_request(32'd3, 32'd5, 32'd2);
      add_request(32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAB);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         kind = $urandom_range(0, 99);
         b = ($urandom_range(0, 3) == 0) ? rand_bits($urandom_range(1, 8)) : $urandom;
         // long exponents are slow, so most stay short
         e = ($urandom_range(0, 3) == 0) ? $urandom : rand_bits($urandom_range(0, 8));
         if (kind < 5) begin
            n = 32'd0;
         end else if (kind < 10) begin
            n = 32'd1;
         end else begin
            w = $urandom_range(1, 32);
            n = rand_bits(w) | (32'd1 << (w - 1));
         end
         add_request(b, e, n);
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (requests_accepted == total_requests);
      while (expected_powers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests sent, %0d results checked (%0d with zero modulus), %0d cycles",
               requests_accepted, results_checked, zero_modulus_results, cycles_elapsed);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", error_count);
         $display("status: fail");
      end
      $finish;
   end

endmodule
